// File: hw/rtl/gpfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian pulse field sampler package
// Shared types, register codes, fixed-point constants and the constant
// functions that build the cosine and fractional power-of-two tables.
// ----------------------------------------------------------------------------
package gpfs_pkg;

  localparam int unsigned DEF_COSINE_TABLE_BITS = 10;
  localparam int unsigned DEF_EXP2_TABLE_BITS   = 8;

  localparam int unsigned PIPE_STAGES = 9;

  // Ticks per position unit in Q0.32.
  localparam logic [30:0] INV_C_Q32 = 31'd895404300;
  // Normalized width saturates at 4.0 in Q.16.
  localparam logic [18:0] N_SAT_Q16 = 19'd262144;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned LN2_Q30    = 64'd744261118;
  localparam longint          ONE_Q30    = 64'sd1073741824;

  localparam logic [14:0] PEAK_AMP_RST  = 15'h7FFF;
  localparam logic [31:0] INV_WIDTH_RST = 32'd65536;

  typedef enum logic [2:0] {
    REG_PEAK_AMP    = 3'd0,
    REG_CARRIER     = 3'd1,
    REG_START_PHASE = 3'd2,
    REG_REFERENCE   = 3'd3,
    REG_INV_WIDTH   = 3'd4
  } gpfs_reg_e;

  typedef struct packed {
    logic [14:0]        peak_amplitude;
    logic [31:0]        carrier_turns_per_tick;
    logic [15:0]        start_phase_turns;
    logic signed [31:0] reference_ticks;
    logic [31:0]        inverse_width;
  } gpfs_cfg_t;

  // Cosine of a table index in signed Q1.15, from a Taylor series on the
  // folded quarter wave.
  function automatic logic signed [16:0] gpfs_cos_entry(input int unsigned k,
                                                        input int unsigned bits);
    longint unsigned    a;
    longint             x;
    longint             x2;
    longint             t;
    logic               neg;
    logic signed [16:0] r;
    a   = (longint'(k) << (32 - bits)) & 64'hFFFF_FFFF;
    neg = 1'b0;
    if (a > 64'h8000_0000) begin
      a = 64'h1_0000_0000 - a;
    end
    if (a > 64'h4000_0000) begin
      neg = 1'b1;
      a   = 64'h8000_0000 - a;
    end
    x  = longint'((a * TWO_PI_Q30) >> 32);
    x2 = (x * x) >>> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 90;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 56;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 30;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 12;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 2;
    if (t < 0) begin
      t = 0;
    end
    t = (t + 16384) >>> 15;
    r = 17'(t);
    return neg ? -r : r;
  endfunction

  // 2^(-f) for a table index in unsigned Q1.16; entry zero is 65536.
  function automatic logic [16:0] gpfs_exp2_entry(input int unsigned i,
                                                  input int unsigned bits);
    longint unsigned y;
    longint          z;
    longint          t;
    y = (longint'(i) << (32 - bits)) & 64'hFFFF_FFFF;
    z = longint'((y * LN2_Q30) >> 32);
    t = ONE_Q30;
    t = ONE_Q30 - ((z * t) >>> 30) / 9;
    t = ONE_Q30 - ((z * t) >>> 30) / 8;
    t = ONE_Q30 - ((z * t) >>> 30) / 7;
    t = ONE_Q30 - ((z * t) >>> 30) / 6;
    t = ONE_Q30 - ((z * t) >>> 30) / 5;
    t = ONE_Q30 - ((z * t) >>> 30) / 4;
    t = ONE_Q30 - ((z * t) >>> 30) / 3;
    t = ONE_Q30 - ((z * t) >>> 30) / 2;
    t = ONE_Q30 - ((z * t) >>> 30) / 1;
    return 17'((t + 8192) >>> 14);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gpfs_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian pulse field sampler datapath
// Nine-stage pipeline from time and position to field and envelope samples.
// All stages advance together on en_i; valid bits travel with the data.
// ----------------------------------------------------------------------------
module gpfs_pipe #(
  parameter int unsigned COSINE_TABLE_BITS = gpfs_pkg::DEF_COSINE_TABLE_BITS,
  parameter int unsigned EXP2_TABLE_BITS   = gpfs_pkg::DEF_EXP2_TABLE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] time_ticks_i,
  input  logic signed [31:0] position_sub_um_i,
  input  gpfs_pkg::gpfs_cfg_t cfg_i,
  output logic               valid_o,
  output logic signed [15:0] field_value_o,
  output logic [15:0]        envelope_value_o
);
  import gpfs_pkg::*;

  localparam int unsigned CosDepth = 1 << COSINE_TABLE_BITS;
  localparam int unsigned ExpDepth = 1 << EXP2_TABLE_BITS;
  localparam logic [31:0] PhaseRound = 32'd1 << (31 - COSINE_TABLE_BITS);
  localparam logic [16:0] ExpRound   = 17'd1 << (15 - EXP2_TABLE_BITS);

  logic signed [16:0] cos_rom [CosDepth];
  logic [16:0]        exp_rom [ExpDepth];

  for (genvar g = 0; g < CosDepth; g++) begin : g_cos_rom
    assign cos_rom[g] = gpfs_cos_entry(g, COSINE_TABLE_BITS);
  end

  for (genvar g = 0; g < ExpDepth; g++) begin : g_exp_rom
    assign exp_rom[g] = gpfs_exp2_entry(g, EXP2_TABLE_BITS);
  end

  logic [PIPE_STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[PIPE_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[PIPE_STAGES-1];

  // Stage 1: time offset and propagation delay.
  logic signed [63:0] dly_prod;
  logic signed [32:0] t_diff;
  logic signed [32:0] s1_t_q;
  logic signed [30:0] s1_d16_q;

  assign dly_prod = position_sub_um_i * $signed({1'b0, INV_C_Q32});
  assign t_diff   = 33'(time_ticks_i) - 33'(cfg_i.reference_ticks);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_t_q   <= t_diff;
      s1_d16_q <= dly_prod[62:32];
    end
  end

  // Stage 2: retarded time and its magnitude.
  logic signed [49:0] tau_pos;
  logic signed [49:0] tau_neg;
  logic signed [49:0] s2_tau_q;
  logic [48:0]        s2_mag_q;

  assign tau_pos = 50'($signed({s1_t_q, 16'h0000})) - 50'(s1_d16_q);
  assign tau_neg = 50'(s1_d16_q) - 50'($signed({s1_t_q, 16'h0000}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_tau_q <= tau_pos;
      s2_mag_q <= tau_pos[49] ? tau_neg[48:0] : tau_pos[48:0];
    end
  end

  // Stage 3: partial products for carrier phase and normalized width.
  logic [63:0] phs_lo_prod;
  logic [15:0] phs_hi_prod;
  logic [48:0] nw_hi_prod;
  logic [63:0] nw_lo_prod;
  logic [31:0] s3_plo_q;
  logic [15:0] s3_phi_q;
  logic [48:0] s3_nh_q;
  logic [31:0] s3_nl_q;

  assign phs_lo_prod = 64'(s2_tau_q[31:0]) * 64'(cfg_i.carrier_turns_per_tick);
  assign phs_hi_prod = s2_tau_q[47:32] * cfg_i.carrier_turns_per_tick[15:0];
  assign nw_hi_prod  = 49'(s2_mag_q[48:32]) * 49'(cfg_i.inverse_width);
  assign nw_lo_prod  = 64'(s2_mag_q[31:0]) * 64'(cfg_i.inverse_width);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_plo_q <= phs_lo_prod[47:16];
      s3_phi_q <= phs_hi_prod;
      s3_nh_q  <= nw_hi_prod;
      s3_nl_q  <= nw_lo_prod[63:32];
    end
  end

  // Stage 4: sum partial products, saturate the normalized width.
  logic [49:0] n_sum;
  logic [31:0] s4_prod_q;
  logic [18:0] s4_n_q;

  assign n_sum = 50'(s3_nh_q) + 50'(s3_nl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_prod_q <= s3_plo_q + {s3_phi_q, 16'h0000};
      s4_n_q    <= (n_sum > 50'(N_SAT_Q16)) ? N_SAT_Q16 : n_sum[18:0];
    end
  end

  // Stage 5: phase wrap and cosine index, square of the normalized width.
  logic [31:0]                  phase_rnd;
  logic [36:0]                  n_sq;
  logic [COSINE_TABLE_BITS-1:0] s5_cidx_q;
  logic [36:0]                  s5_nsq_q;

  assign phase_rnd = {cfg_i.start_phase_turns, 16'h0000} + PhaseRound - s4_prod_q;
  assign n_sq      = 37'(s4_n_q) * 37'(s4_n_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_cidx_q <= phase_rnd[31:32-COSINE_TABLE_BITS];
      s5_nsq_q  <= n_sq;
    end
  end

  // Stage 6: cosine lookup, split the exponent into shift and table index.
  logic [15:0]                exp_frac;
  logic [16:0]                exp_rsum;
  logic [EXP2_TABLE_BITS:0]   exp_ridx;
  logic signed [16:0]         s6_cos_q;
  logic [EXP2_TABLE_BITS-1:0] s6_eidx_q;
  logic [5:0]                 s6_eshf_q;

  assign exp_frac = {s5_nsq_q[30:16], 1'b0};
  assign exp_rsum = {1'b0, exp_frac} + ExpRound;
  assign exp_ridx = exp_rsum[16:16-EXP2_TABLE_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_cos_q  <= cos_rom[s5_cidx_q];
      s6_eidx_q <= exp_ridx[EXP2_TABLE_BITS] ? '0 : exp_ridx[EXP2_TABLE_BITS-1:0];
      s6_eshf_q <= s5_nsq_q[36:31] + 6'(exp_ridx[EXP2_TABLE_BITS]);
    end
  end

  // Stage 7: envelope table lookup, amplitude times cosine magnitude.
  logic [15:0] cos_mag;
  logic [16:0] s7_env_tab_q;
  logic [5:0]  s7_eshf_q;
  logic [30:0] s7_ac_q;
  logic        s7_neg_q;

  assign cos_mag = s6_cos_q[16] ? 16'(-s6_cos_q) : 16'(s6_cos_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s7_env_tab_q <= exp_rom[s6_eidx_q];
      s7_eshf_q    <= s6_eshf_q;
      s7_ac_q      <= 31'(cfg_i.peak_amplitude) * 31'(cos_mag);
      s7_neg_q     <= s6_cos_q[16];
    end
  end

  // Stage 8: rounding right shift of the envelope.
  logic [17:0] env_half;
  logic [16:0] env_rnd;
  logic [16:0] env_next;
  logic [16:0] s8_env_q;
  logic [30:0] s8_ac_q;
  logic        s8_neg_q;

  always_comb begin
    env_half = {s7_env_tab_q, 1'b0} >> s7_eshf_q;
    env_rnd  = 17'((19'(env_half) + 19'd1) >> 1);
    if (s7_eshf_q >= 6'd17) begin
      env_next = '0;
    end else if (s7_eshf_q == 6'd0) begin
      env_next = s7_env_tab_q;
    end else begin
      env_next = env_rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s8_env_q <= env_next;
      s8_ac_q  <= s7_ac_q;
      s8_neg_q <= s7_neg_q;
    end
  end

  // Stage 9: field magnitude.
  logic [46:0] s9_mag_q;
  logic [16:0] s9_env_q;
  logic        s9_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s9_mag_q <= 47'(s8_ac_q) * 47'(s8_env_q);
      s9_env_q <= s8_env_q;
      s9_neg_q <= s8_neg_q;
    end
  end

  // Rounding to Q1.15 and saturation.
  logic [47:0] mag_rnd;
  logic [16:0] q_raw;
  logic [16:0] q_sat;

  always_comb begin
    mag_rnd = 48'(s9_mag_q) + 48'h0000_4000_0000;
    q_raw   = mag_rnd[47:31];
    q_sat   = (q_raw > 17'd32768) ? 17'd32768 : q_raw;
    if (s9_neg_q) begin
      field_value_o = 16'(17'd0 - q_sat);
    end else if (q_sat > 17'd32767) begin
      field_value_o = 16'sh7FFF;
    end else begin
      field_value_o = 16'(q_sat);
    end
    envelope_value_o = s9_env_q[16] ? 16'hFFFF : s9_env_q[15:0];
  end

endmodule
`default_nettype wire

// File: hw/rtl/gaussian_pulse_field_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian pulse field sampler
// Samples a Gaussian-enveloped carrier at a given time and position.
//
//   Channel  Dir  Payload
//   s_axis   in   time_ticks, position_sub_um
//   m_axis   out  field_value, envelope_value
//   apb      in   register writes and reads
//
// One beat is accepted per clock cycle while s_axis_tready is high; results pass
// through the nine arithmetic stages and then the output register.
// Reset clears all valid bits and loads the registers with their defaults.
// A stall on m_axis fills the output register and then a skid register;
// only when both are full does the whole pipeline hold and s_axis_tready drop.
// ----------------------------------------------------------------------------
module gaussian_pulse_field_sampler #(
  parameter int unsigned COSINE_TABLE_BITS = gpfs_pkg::DEF_COSINE_TABLE_BITS,
  parameter int unsigned EXP2_TABLE_BITS   = gpfs_pkg::DEF_EXP2_TABLE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] time_ticks, [63:32] position_sub_um
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] field_value, [31:16] envelope_value
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gpfs_pkg::*;

  gpfs_cfg_t cfg_q;
  gpfs_cfg_t cfg_d;
  gpfs_reg_e reg_sel;
  logic      cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = gpfs_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_PEAK_AMP:    cfg_d.peak_amplitude         = pwdata[14:0];
        REG_CARRIER:     cfg_d.carrier_turns_per_tick = pwdata;
        REG_START_PHASE: cfg_d.start_phase_turns      = pwdata[15:0];
        REG_REFERENCE:   cfg_d.reference_ticks        = $signed(pwdata);
        REG_INV_WIDTH:   cfg_d.inverse_width          = pwdata;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PEAK_AMP:    prdata = {17'h0, cfg_q.peak_amplitude};
      REG_CARRIER:     prdata = cfg_q.carrier_turns_per_tick;
      REG_START_PHASE: prdata = {16'h0, cfg_q.start_phase_turns};
      REG_REFERENCE:   prdata = cfg_q.reference_ticks;
      REG_INV_WIDTH:   prdata = cfg_q.inverse_width;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_amplitude         <= PEAK_AMP_RST;
      cfg_q.carrier_turns_per_tick <= '0;
      cfg_q.start_phase_turns      <= '0;
      cfg_q.reference_ticks        <= '0;
      cfg_q.inverse_width          <= INV_WIDTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic               pipe_en;
  logic               pipe_vld;
  logic signed [15:0] pipe_field;
  logic [15:0]        pipe_env;

  gpfs_pipe #(
    .COSINE_TABLE_BITS (COSINE_TABLE_BITS),
    .EXP2_TABLE_BITS   (EXP2_TABLE_BITS)
  ) u_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (pipe_en),
    .valid_i           (s_axis_tvalid),
    .time_ticks_i      ($signed(s_axis_tdata[31:0])),
    .position_sub_um_i ($signed(s_axis_tdata[63:32])),
    .cfg_i             (cfg_q),
    .valid_o           (pipe_vld),
    .field_value_o     (pipe_field),
    .envelope_value_o  (pipe_env)
  );

  logic        out_valid_q;
  logic        out_valid_d;
  logic        skid_valid_q;
  logic        skid_valid_d;
  logic [31:0] out_data_q;
  logic [31:0] skid_data_q;
  logic        push;
  logic        out_load_pipe;
  logic        out_load_skid;
  logic        skid_load;

  assign pipe_en       = !pipe_vld || !skid_valid_q;
  assign s_axis_tready = pipe_en;
  assign push          = pipe_vld && !skid_valid_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    out_load_pipe = 1'b0;
    out_load_skid = 1'b0;
    skid_load     = 1'b0;
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_load_skid = 1'b1;
        out_valid_d   = 1'b1;
        skid_valid_d  = 1'b0;
      end else begin
        out_load_pipe = push;
        out_valid_d   = push;
      end
    end else if (push) begin
      skid_load    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_skid) begin
      out_data_q <= skid_data_q;
    end else if (out_load_pipe) begin
      out_data_q <= {pipe_env, pipe_field};
    end
    if (skid_load) begin
      skid_data_q <= {pipe_env, pipe_field};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (skid_valid_q && pipe_vld && out_valid_q))
    else $error("input stalled while the output side had room");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_axis_tready) |=> m_axis_tvalid)
    else $error("skid beat lost when the output register drained");

  a_amp_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && reg_sel == REG_PEAK_AMP)
      |=> cfg_q.peak_amplitude == $past(pwdata[14:0]))
    else $error("peak amplitude register not updated by its write");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian pulse field sampler testbench
// Drives time and position beats through the sampler under random bursts and
// output stalls, predicts every field and envelope sample with a fixed-point
// model of its own, and compares each result beat in order. Register settings
// are changed between phases while the pipeline is empty and read back.
// ----------------------------------------------------------------------------
module tb_top;
  import gpfs_pkg::*;

  localparam int unsigned COS_BITS     = DEF_COSINE_TABLE_BITS;
  localparam int unsigned EXP_BITS     = DEF_EXP2_TABLE_BITS;
  localparam int unsigned PIPE_LATENCY = PIPE_STAGES + 1;
  localparam int unsigned REG_COUNT    = 5;
  localparam int unsigned ADDR_SLOTS   = 8;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_SAMPLES = 90;

  localparam longint unsigned RADIANS_PER_TURN_Q30 = 64'd6746518852;
  localparam longint unsigned LN2_Q30_C            = 64'd744261118;
  localparam longint          UNITY_Q30            = 64'sd1073741824;
  localparam longint          TICKS_PER_POS_Q32    = 64'sd895404300;
  localparam longint unsigned NORM_LIMIT_Q16       = 64'd262144;
  localparam longint unsigned LOW32                = 64'hFFFF_FFFF;

  typedef struct {
    logic signed [31:0] time_ticks;
    logic signed [31:0] position_sub_um;
  } probe_point_t;

  typedef struct {
    logic signed [15:0] field_value;
    logic [15:0]        envelope_value;
  } field_sample_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSED} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gpfs_cfg_t cfg = '{PEAK_AMP_RST, 32'd0, 16'd0, 32'sd0, INV_WIDTH_RST};

  probe_point_t  point_q[$];
  field_sample_t sample_q[$];
  logic          in_fire = 1'b0;
  int unsigned   results_seen = 0;
  int unsigned   mismatches = 0;

  gaussian_pulse_field_sampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint cosine_q15(input longint unsigned k);
    longint unsigned ang;
    longint          x;
    longint          x2;
    longint          acc;
    bit              flip;
    ang  = (k << (32 - COS_BITS)) & LOW32;
    flip = 1'b0;
    if (ang > 64'h8000_0000) begin
      ang = 64'h1_0000_0000 - ang;
    end
    if (ang > 64'h4000_0000) begin
      flip = 1'b1;
      ang  = 64'h8000_0000 - ang;
    end
    x   = longint'((ang * RADIANS_PER_TURN_Q30) >> 32);
    x2  = (x * x) >>> 30;
    acc = UNITY_Q30;
    for (int j = 5; j >= 1; j--) begin
      acc = UNITY_Q30 - ((x2 * acc) >>> 30) / longint'((2 * j) * (2 * j - 1));
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> 15;
    return flip ? -acc : acc;
  endfunction

  function automatic longint unsigned exp2_frac_q16(input longint unsigned i);
    longint unsigned y;
    longint          z;
    longint          acc;
    y   = (i << (32 - EXP_BITS)) & LOW32;
    z   = longint'((y * LN2_Q30_C) >> 32);
    acc = UNITY_Q30;
    for (int j = 9; j >= 1; j--) begin
      acc = UNITY_Q30 - ((z * acc) >>> 30) / longint'(j);
    end
    return longint'((acc + 8192) >>> 14);
  endfunction

  function automatic field_sample_t predict_sample(input logic signed [31:0] t_in,
                                                   input logic signed [31:0] p_in);
    longint          rel;
    longint          dly;
    longint          tau;
    longint unsigned tau_u;
    longint unsigned carrier;
    longint unsigned mix;
    longint unsigned ph;
    longint unsigned ci;
    longint          c;
    longint unsigned cm;
    longint unsigned mg;
    longint unsigned iw;
    longint unsigned nq;
    longint unsigned sq;
    longint unsigned ex;
    longint unsigned fr;
    longint unsigned ei;
    longint unsigned env;
    longint unsigned mag;
    longint unsigned q;
    longint          fld;
    field_sample_t   r;
    rel   = longint'(t_in) - longint'($signed(cfg.reference_ticks));
    dly   = (longint'(p_in) * TICKS_PER_POS_Q32) >>> 32;
    tau   = rel * 65536 - dly;
    tau_u = tau;
    carrier = 64'(cfg.carrier_turns_per_tick);
    mix   = (tau_u * carrier) >> 16;
    ph    = ((longint'(cfg.start_phase_turns) << 16) - mix) & LOW32;
    ci    = ((ph + (64'd1 << (31 - COS_BITS))) >> (32 - COS_BITS)) &
            ((64'd1 << COS_BITS) - 1);
    c     = cosine_q15(ci);
    cm    = (c < 0) ? -c : c;

    mg = (tau < 0) ? -tau : tau;
    iw = 64'(cfg.inverse_width);
    nq = (mg >> 32) * iw + (((mg & LOW32) * iw) >> 32);
    if (nq > NORM_LIMIT_Q16) begin
      nq = NORM_LIMIT_Q16;
    end
    sq = ((nq * nq) >> 16) * 2;
    ex = sq >> 16;
    fr = sq & 64'hFFFF;
    ei = (fr + (64'd1 << (15 - EXP_BITS))) >> (16 - EXP_BITS);
    if (ei >= (64'd1 << EXP_BITS)) begin
      ei = 0;
      ex = ex + 1;
    end
    env = exp2_frac_q16(ei);
    if (ex >= 17) begin
      env = 0;
    end else if (ex > 0) begin
      env = (env + (64'd1 << (ex - 1))) >> ex;
    end

    mag = longint'(cfg.peak_amplitude) * cm * env;
    q   = (mag + (64'd1 << 30)) >> 31;
    if (q > 32768) begin
      q = 32768;
    end
    fld = (c < 0) ? -longint'(q) : longint'(q);
    if (fld > 32767) begin
      fld = 32767;
    end
    r.field_value    = fld[15:0];
    r.envelope_value = (env > 65535) ? 16'hFFFF : env[15:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint expv, input longint actv);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin : drive_points
    logic        nv;
    logic [63:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (in_fire) begin
      point_q.delete(0);
    end
    if (!s_axis_tvalid || in_fire) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (point_q.size() != 0) begin
        nv = 1'b1;
        nd = {point_q[0].position_sub_um, point_q[0].time_ticks};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left--;
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
  end

  // Receiver: random stall patterns in turn, plus one long hold.
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;
  logic [7:0]  rx_tick = '0;

  always @(negedge clk_i) begin : drive_ready
    logic nr;
    rx_tick++;
    if (!long_hold_done && results_seen >= 150) begin
      hold_left      = 300;
      long_hold_done = 1'b1;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(8, 64);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_OPEN:   nr = 1'b1;
      RX_COIN:   nr = 1'($urandom_range(0, 1));
      RX_SPARSE: nr = ($urandom_range(0, 3) == 0);
      default:   nr = rx_tick[2];
    endcase
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end
    m_axis_tready <= nr;
  end

  always @(posedge clk_i) begin : track_beats
    field_sample_t want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sample_q.push_back(predict_sample(s_axis_tdata[31:0], s_axis_tdata[63:32]));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (sample_q.size() == 0) begin
        flag_mismatch("unexpected result beat, pending count", 0, 1);
      end else begin
        want = sample_q.pop_front();
        if (m_axis_tdata[15:0] !== want.field_value) begin
          flag_mismatch("field_value", longint'(want.field_value),
                        longint'($signed(m_axis_tdata[15:0])));
        end
        if (m_axis_tdata[31:16] !== want.envelope_value) begin
          flag_mismatch("envelope_value", longint'(want.envelope_value),
                        longint'(m_axis_tdata[31:16]));
        end
      end
    end
  end

  task automatic write_reg(input int unsigned idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 5'(idx * 4);
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_PEAK_AMP:    cfg.peak_amplitude         = val[14:0];
      REG_CARRIER:     cfg.carrier_turns_per_tick = val;
      REG_START_PHASE: cfg.start_phase_turns      = val[15:0];
      REG_REFERENCE:   cfg.reference_ticks        = val;
      REG_INV_WIDTH:   cfg.inverse_width          = val;
      default: ;
    endcase
  endtask

  task automatic check_all_regs();
    logic [31:0] want;
    logic [31:0] got;
    for (int unsigned idx = 0; idx < REG_COUNT; idx++) begin
      case (idx)
        REG_PEAK_AMP:    want = {17'd0, cfg.peak_amplitude};
        REG_CARRIER:     want = cfg.carrier_turns_per_tick;
        REG_START_PHASE: want = {16'd0, cfg.start_phase_turns};
        REG_REFERENCE:   want = cfg.reference_ticks;
        default:         want = cfg.inverse_width;
      endcase
      @(negedge clk_i);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = 5'(idx * 4);
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      got = prdata;
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== want) begin
        flag_mismatch($sformatf("register %0d readback", idx), longint'(want),
                      longint'(got));
      end
    end
  endtask

  task automatic apply_settings(input logic [31:0] peak, input logic [31:0] carrier,
                                input logic [31:0] phase0, input logic [31:0] ref_t,
                                input logic [31:0] inv_w);
    write_reg(REG_PEAK_AMP, peak);
    write_reg(REG_CARRIER, carrier);
    write_reg(REG_START_PHASE, phase0);
    write_reg(REG_REFERENCE, ref_t);
    write_reg(REG_INV_WIDTH, inv_w);
    check_all_regs();
  endtask

  task automatic queue_point(input logic [31:0] t, input logic [31:0] p);
    probe_point_t pt;
    pt.time_ticks      = t;
    pt.position_sub_um = p;
    point_q.push_back(pt);
  endtask

  task automatic wait_idle();
    while (point_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LATENCY + 6) @(posedge clk_i);
  endtask

  initial begin : run_phases
    longint unsigned span;
    longint          off;
    logic signed [31:0] pos;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values, then field extremes with an untouched carrier.
    check_all_regs();
    queue_point(32'h0000_0000, 32'h0000_0000);
    queue_point(32'h7FFF_FFFF, 32'h0000_0000);
    queue_point(32'h8000_0000, 32'h0000_0000);
    queue_point(32'h0000_0000, 32'h7FFF_FFFF);
    queue_point(32'h0000_0000, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF);
    queue_point(32'h0000_0001, 32'h0000_0000);
    queue_point(32'hFFFF_FFFF, 32'h0000_0000);
    queue_point(32'h0000_0010, 32'hFFFF_FFB3);
    wait_idle();

    // Writes past the last register must leave every register unchanged.
    for (int unsigned k = REG_COUNT; k < ADDR_SLOTS; k++) begin
      write_reg(k, $urandom);
    end
    check_all_regs();

    // Quarter-turn carrier with a zero inverse width: flat envelope, cosine of all signs.
    apply_settings(32'h7FFF, 32'h4000_0000, 32'h8000, 32'hFFFF_FFFB, 32'h0);
    for (int k = -5; k < 3; k++) begin
      queue_point(k, 32'h0);
    end
    queue_point(32'h7FFF_FFFF, 32'h8000_0000);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: apply_settings(32'h7FFF, 32'hFFFF_FFFF, 32'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        1: apply_settings(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h1);
        default: apply_settings($urandom_range(0, 32767), $urandom, $urandom_range(0, 65535),
                                $urandom, ($urandom >> $urandom_range(0, 28)) | 32'h1);
      endcase
      for (int unsigned n = 0; n < PHASE_SAMPLES; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          // Near the reference in time, at normalized widths of up to five.
          span = (cfg.inverse_width == 0) ? 64'h7FFF_FFFF :
                 ((64'd5 << 32) / cfg.inverse_width);
          if (span > 64'h7FFF_FFFF) begin
            span = 64'h7FFF_FFFF;
          end
          off = longint'($urandom_range(0, 32'(span)));
          if ($urandom_range(0, 1) == 1) begin
            off = -off;
          end
          pos = $signed($urandom) >>> $urandom_range(8, 31);
          queue_point(32'(longint'($signed(cfg.reference_ticks)) + off), pos);
        end else begin
          queue_point($urandom, $urandom);
        end
      end
      wait_idle();
    end

    repeat (PIPE_LATENCY * 2) @(posedge clk_i);
    if (sample_q.size() != 0) begin
      flag_mismatch("results still outstanding", 0, longint'(sample_q.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
